// ----- rtl/tvsg_pkg.sv -----
// Shared constants and types for the three-voice sound generator.
package tvsg_pkg;

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Register map
  localparam logic [3:0] REG_TONE_C_HI  = 4'd5;
  localparam logic [3:0] REG_NOISE_PER  = 4'd6;
  localparam logic [3:0] REG_MIXER      = 4'd7;
  localparam logic [3:0] REG_AMP_A      = 4'd8;
  localparam logic [3:0] REG_ENV_PER_LO = 4'd11;
  localparam logic [3:0] REG_ENV_PER_HI = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;
  localparam int         REG_COUNT      = 14;
  localparam int         NUM_VOICES     = 3;

  // Envelope shapes after folding shapes 0..7 onto their single-shot forms
  localparam logic [3:0] ENV_SHP_SAW_DOWN  = 4'd8;
  localparam logic [3:0] ENV_SHP_DOWN_ONCE = 4'd9;
  localparam logic [3:0] ENV_SHP_TRI_DOWN  = 4'd10;
  localparam logic [3:0] ENV_SHP_DOWN_HIGH = 4'd11;
  localparam logic [3:0] ENV_SHP_SAW_UP    = 4'd12;
  localparam logic [3:0] ENV_SHP_UP_HOLD   = 4'd13;
  localparam logic [3:0] ENV_SHP_TRI_UP    = 4'd14;
  localparam logic [3:0] ENV_SHP_UP_ONCE   = 4'd15;

  localparam logic [3:0] ENV_LEVEL_MAX = 4'd15;

  typedef logic [7:0]  reg_byte_t;
  typedef logic [11:0] tone_period_t;
  typedef logic [4:0]  noise_period_t;
  typedef logic [15:0] env_period_t;
  typedef logic [3:0]  env_level_t;

  // Per-voice control from the front end
  typedef struct packed {
    logic tick;
    logic clear;
  } tone_ctl_t;

endpackage

// ----- rtl/tvsg_tone.sv -----
// One square-wave tone divider with its output level.
module tvsg_tone
  import tvsg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  tone_ctl_t    ctl,
  input  tone_period_t period,
  output logic         level_nxt
);

  tone_period_t cnt_r, cnt_nxt, cnt_inc;
  logic         level_r;

  assign cnt_inc = cnt_r + tone_period_t'(2);

  // Advance the counter by two per tick and toggle at the period
  always_comb begin
    cnt_nxt   = cnt_r;
    level_nxt = level_r;
    if (ctl.clear) begin
      cnt_nxt = '0;
    end else if (ctl.tick) begin
      if (period != '0) begin
        if (cnt_inc == period) begin
          cnt_nxt   = '0;
          level_nxt = ~level_r;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end else begin
        level_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      level_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

// ----- rtl/tvsg_noise.sv -----
// Noise divider clocking a 16-bit Fibonacci LFSR.
module tvsg_noise
  import tvsg_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tick,
  input  noise_period_t period,
  output logic          bit_nxt
);

  noise_period_t cnt_r, cnt_nxt, cnt_inc;
  logic [15:0]   lfsr_r, lfsr_nxt;
  logic          bit_r;
  logic          fb;

  assign cnt_inc = cnt_r + noise_period_t'(1);
  assign fb      = lfsr_r[10] ^ lfsr_r[12] ^ lfsr_r[13] ^ lfsr_r[15];

  // Step the LFSR each time the divider reaches the period
  always_comb begin
    cnt_nxt  = cnt_r;
    lfsr_nxt = lfsr_r;
    bit_nxt  = bit_r;
    if (tick && period != '0) begin
      if (cnt_inc == period) begin
        cnt_nxt  = '0;
        lfsr_nxt = {lfsr_r[14:0], fb};
        bit_nxt  = fb;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lfsr_r <= 16'h0001;
      bit_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      lfsr_r <= lfsr_nxt;
      bit_r  <= bit_nxt;
    end
  end

endmodule

// ----- rtl/tvsg_env.sv -----
// Envelope generator: prescaler, period divider and shape sequencer.
module tvsg_env
  import tvsg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tick,
  input  logic        restart,
  input  logic [3:0]  shape,
  input  env_period_t period,
  output env_level_t  level_nxt
);

  typedef enum logic [2:0] {
    ENV_IDLE = 3'b001,
    ENV_FALL = 3'b010,
    ENV_RISE = 3'b100
  } env_phase_t;

  env_phase_t  phase_r, phase_nxt;
  env_level_t  level_r;
  logic [3:0]  pre_r, pre_nxt;
  env_period_t cnt_r, cnt_nxt, cnt_inc;
  logic [3:0]  shp;
  logic        step;
  logic        lvl_zero, lvl_max;

  // Fold shapes 0..7 onto the single-shot fall and rise
  assign shp = shape[3] ? shape : (shape[2] ? ENV_SHP_UP_ONCE : ENV_SHP_DOWN_ONCE);

  assign cnt_inc  = cnt_r + env_period_t'(1);
  assign lvl_zero = (level_r == '0);
  assign lvl_max  = (level_r == ENV_LEVEL_MAX);

  // Divider: count only when the prescaler is at zero
  always_comb begin
    cnt_nxt = cnt_r;
    pre_nxt = pre_r;
    step    = 1'b0;
    if (restart) begin
      cnt_nxt = '0;
      pre_nxt = '0;
    end else if (tick) begin
      pre_nxt = pre_r + 4'd1;
      if (pre_r == '0 && period != '0) begin
        if (cnt_inc == period) begin
          cnt_nxt = '0;
          step    = 1'b1;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
    end
  end

  // Shape sequencer
  always_comb begin
    level_nxt = level_r;
    phase_nxt = phase_r;
    if (restart) begin
      if (shp == ENV_SHP_TRI_UP) begin
        level_nxt = ENV_LEVEL_MAX;
        phase_nxt = ENV_RISE;
      end else if (shp == ENV_SHP_DOWN_ONCE || shp == ENV_SHP_SAW_DOWN ||
                   shp == ENV_SHP_TRI_DOWN || shp == ENV_SHP_DOWN_HIGH) begin
        level_nxt = ENV_LEVEL_MAX;
        phase_nxt = ENV_FALL;
      end else begin
        level_nxt = '0;
        phase_nxt = ENV_FALL;
      end
    end else if (step && phase_r != ENV_IDLE) begin
      case (shp)
        ENV_SHP_DOWN_ONCE: begin
          if (!lvl_zero) level_nxt = level_r - 4'd1;
          else phase_nxt = ENV_IDLE;
        end
        ENV_SHP_UP_ONCE: begin
          if (!lvl_max) level_nxt = level_r + 4'd1;
          else begin
            level_nxt = '0;
            phase_nxt = ENV_IDLE;
          end
        end
        ENV_SHP_SAW_DOWN: level_nxt = level_r - 4'd1;
        ENV_SHP_SAW_UP:   level_nxt = level_r + 4'd1;
        ENV_SHP_DOWN_HIGH: begin
          if (!lvl_zero) level_nxt = level_r - 4'd1;
          else begin
            level_nxt = ENV_LEVEL_MAX;
            phase_nxt = ENV_IDLE;
          end
        end
        ENV_SHP_TRI_DOWN, ENV_SHP_TRI_UP: begin
          if (phase_r == ENV_FALL) begin
            if (!lvl_zero) level_nxt = level_r - 4'd1;
            else phase_nxt = ENV_RISE;
          end else begin
            if (!lvl_max) level_nxt = level_r + 4'd1;
            else phase_nxt = ENV_FALL;
          end
        end
        ENV_SHP_UP_HOLD: begin
          if (!lvl_max) level_nxt = level_r + 4'd1;
          else phase_nxt = ENV_IDLE;
        end
        default: begin
          level_nxt = level_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ENV_IDLE;
      level_r <= '0;
      pre_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      pre_r   <= pre_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/three_voice_sound_generator.sv -----
// Top level: input register, register file, generators, mixer and output register.
//
//   channel  ports                                        direction
//   in       in_valid/in_ready, in_command, in_reg_index,  in
//            in_write_data
//   out      out_valid/out_ready, out_sample               out
//
// Each word waits in the input register until it advances; as it does, its state
// update is registered and, for a tick, the mixed sample loads the output register.
// One word per cycle is sustained while the output is taken; a register write
// yields no output word. A tick waits in the input register only while the
// output register holds an untaken sample; writes pass regardless. Synchronous
// active-low reset loads the valid flags, register file and generator state.
module three_voice_sound_generator
  import tvsg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [3:0] in_reg_index,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [8:0] out_sample
);

  logic       in_valid_r;
  logic       cmd_r;
  logic [3:0] idx_r;
  reg_byte_t  data_r;
  logic       out_valid_r, out_valid_nxt;
  logic [8:0] sample_r;

  reg_byte_t  regs_r [REG_COUNT];

  logic       advance, tick, wr;
  logic [NUM_VOICES-1:0] tone_lvl;
  logic       noise_bit;
  env_level_t env_lvl;
  logic [7:0] voice_val [NUM_VOICES];
  logic [9:0] total;

  // Process the held word unless a tick would overwrite an untaken sample
  assign advance  = in_valid_r && (cmd_r == CMD_WRITE || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign tick     = advance && cmd_r == CMD_TICK;
  assign wr       = advance && cmd_r == CMD_WRITE && idx_r < 4'(REG_COUNT);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      cmd_r  <= in_command;
      idx_r  <= in_reg_index;
      data_r <= in_write_data;
    end
  end

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) regs_r[i] <= '0;
    end else if (wr) begin
      regs_r[idx_r] <= data_r;
    end
  end

  // Tone voices
  for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice
    tone_ctl_t    ctl;
    tone_period_t per;
    reg_byte_t    amp_reg;
    logic         tone_off, noise_off;
    env_level_t   amp;
    logic [7:0]   part_t, part_n;

    assign ctl.tick  = tick;
    assign ctl.clear = wr && idx_r <= REG_TONE_C_HI && idx_r[3:1] == 3'(v);
    assign per       = {regs_r[2*v+1][3:0], regs_r[2*v][7:1], 1'b0};

    tvsg_tone u_tone (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .period    (per),
      .level_nxt (tone_lvl[v])
    );

    // Mix this voice from the updated levels
    assign amp_reg   = regs_r[REG_AMP_A + 4'(v)];
    assign tone_off  = regs_r[REG_MIXER][v];
    assign noise_off = regs_r[REG_MIXER][v+3];
    assign amp       = amp_reg[4] ? env_lvl : amp_reg[3:0];
    assign part_t    = (!tone_off && tone_lvl[v]) ? {1'b0, amp, 3'b000} : 8'd0;
    assign part_n    = (!noise_off && noise_bit) ? {2'b00, amp, 2'b00} : 8'd0;
    assign voice_val[v] = (tone_off && noise_off) ?
                          ({1'b0, env_lvl, 3'b000} + {2'b00, env_lvl, 2'b00}) :
                          (part_t + part_n);
  end

  tvsg_noise u_noise (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick    (tick),
    .period  (regs_r[REG_NOISE_PER][4:0]),
    .bit_nxt (noise_bit)
  );

  tvsg_env u_env (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .restart   (wr && idx_r == REG_ENV_SHAPE),
    .shape     ((wr && idx_r == REG_ENV_SHAPE) ? data_r[3:0] : regs_r[REG_ENV_SHAPE][3:0]),
    .period    ({regs_r[REG_ENV_PER_HI], regs_r[REG_ENV_PER_LO]}),
    .level_nxt (env_lvl)
  );

  assign total = 10'(voice_val[0]) + 10'(voice_val[1]) + 10'(voice_val[2]);

  // Output register: load on a tick, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tick) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) sample_r <= total[9:1];
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;

endmodule
